[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked checks shared by the dehaze restore modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

[sv/dph_pkg.sv]
// ----------------------------------------------------------------------------
// dph_pkg
// Shared types and constants of the dehaze pixel restore block.
// ----------------------------------------------------------------------------
`default_nettype none

package dph_pkg;

  localparam int PIX_W       = 8;
  localparam int TRANS_W     = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int GAMMA_DEPTH = 256;
  localparam int COL_W       = 6;
  localparam int SUM_W       = 12;
  localparam int STEP_LIMIT  = 20;
  localparam int SUM_LIMIT   = 30;

  localparam logic [COL_W-1:0]   COUNT_MAX = 6'd63;
  localparam logic [PIX_W-1:0]   AIR_RST   = 8'd255;
  localparam logic [TRANS_W-1:0] FLOOR_RST = 13'd410;
  localparam logic [TRANS_W-1:0] THR_RST   = 13'd1638;

  // Request kinds carried in tuser
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TABLE = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AIR0      = 3'd0,
    CFG_AIR1      = 3'd1,
    CFG_AIR2      = 3'd2,
    CFG_FLOOR     = 3'd3,
    CFG_POST_EN   = 3'd4,
    CFG_THRESHOLD = 3'd5
  } cfg_idx_t;

  // Source of an output pixel
  typedef enum logic [1:0] {
    SRC_PX    = 2'd0,
    SRC_HEAD  = 2'd1,
    SRC_FLUSH = 2'd2
  } emit_src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      gam_wr;
    logic [2:0] rd_ch;
    logic [2:0] cap_ch;
    logic      shift;
    logic      db1;
    logic      db2;
    logic      db3;
    logic      db4;
    logic      emit;
    logic      last;
    emit_src_t src;
    logic      pend_dec;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic post_en;
    logic pend_zero;
    logic pend_one;
    logic pend_full;
    logic col_test;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[sv/dph_ram.sv]
// ----------------------------------------------------------------------------
// dph_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/dph_div.sv]
// ----------------------------------------------------------------------------
// dph_div
// Bit-serial restoring divider for one channel: floor((I-A)*2^F/d) + A,
// clamped to 0..255. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dph_div import dph_pkg::*; #(
  parameter int TFB = 12,
  parameter int DW  = 13
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [PIX_W-1:0] pix,
  input  wire logic [PIX_W-1:0] air,
  input  wire logic [DW-1:0]    dvs,
  output logic                  done,
  output logic [PIX_W-1:0]      res
);

  localparam int NW = PIX_W + TFB;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvr;
  logic          neg;
  logic [PIX_W-1:0] air_q;
  logic [PIX_W-1:0] diff;
  logic [DW:0]   trial;
  logic          ge;
  logic signed [NW+1:0] qs;
  logic signed [NW+1:0] rs;

  assign diff  = (pix >= air) ? (pix - air) : (air - pix);
  assign trial = {rem, quo[NW-1]};
  assign ge    = (trial >= {1'b0, dvr});

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= {diff, {TFB{1'b0}}};
      rem   <= '0;
      dvr   <= dvs;
      neg   <= (pix < air);
      air_q <= air;
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, dvr}) : trial[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

  // Round towards minus infinity, add airlight back and clamp
  always_comb begin
    if (neg) begin
      qs = -$signed({2'b00, quo}) - $signed((NW+2)'(rem != '0));
    end else begin
      qs = $signed({2'b00, quo});
    end
    rs = qs + $signed((NW+2)'(air_q));
    if (rs < 0) begin
      res = '0;
    end else if (rs > $signed((NW+2)'(255))) begin
      res = 8'd255;
    end else begin
      res = rs[PIX_W-1:0];
    end
  end

  assign done = !busy;

endmodule

`default_nettype wire

[sv/dph_dp.sv]
// ----------------------------------------------------------------------------
// dph_dp
// Datapath: configuration registers, channel dividers, gamma table,
// row window with debanding ramp, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dph_dp import dph_pkg::*; #(
  parameter int LOOKBACK = 20,
  parameter int RAMP_LEN = 10,
  parameter int TFB      = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic [PIX_W-1:0]      pixel_c0,
  input  wire logic [PIX_W-1:0]      pixel_c1,
  input  wire logic [PIX_W-1:0]      pixel_c2,
  input  wire logic [TRANS_W-1:0]    transmission,
  input  wire logic [PIX_W-1:0]      table_index,
  input  wire logic [PIX_W-1:0]      table_value,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [3*PIX_W-1:0]         m_tdata,
  output logic                       m_tlast
);

  localparam int WIN  = LOOKBACK + RAMP_LEN + 2;
  localparam int IW   = $clog2(WIN);
  localparam int PW   = $clog2(WIN + 1);
  localparam int DW   = (TFB + 1 > TRANS_W) ? TFB + 1 : TRANS_W;
  localparam int PA   = RAMP_LEN + 1;
  localparam int PB   = RAMP_LEN;
  localparam int PF   = 0;
  localparam int PN   = 2 * RAMP_LEN;
  localparam int DMW  = $clog2(STEP_LIMIT);
  localparam int MW   = $clog2(RAMP_LEN * (STEP_LIMIT - 1) + 1);
  localparam int RK   = 16;
  localparam int MPW  = MW + RK + 1;
  localparam logic [MPW-1:0] RECIP = MPW'((2 ** RK + RAMP_LEN - 1) / RAMP_LEN);
  localparam logic [DW-1:0]  ONE   = DW'(1) << TFB;

  // Configuration
  logic [PIX_W-1:0]   air [3];
  logic [TRANS_W-1:0] trans_floor;
  logic               post_enable;
  logic [TRANS_W-1:0] post_trans_threshold;

  // Item and pixel state
  logic [DW-1:0]    t_sat;
  logic [DW-1:0]    dvs;
  logic [PIX_W-1:0] pix_in [3];
  logic [PIX_W-1:0] px [3];
  logic             mark_q;
  logic [2:0]       div_done;
  logic [PIX_W-1:0] div_res [3];
  logic [PIX_W-1:0] raddr;
  logic [PIX_W-1:0] rdata;

  // Row window
  logic [3*PIX_W-1:0] win [WIN];
  logic [WIN-1:0]     marks;
  logic [PW-1:0]      pending;
  logic [COL_W-1:0]   col;
  logic [IW-1:0]      flush_idx;

  // Debanding pipeline
  logic [8:0]         dsg [3];
  logic [2:0]         st_ok;
  logic [SUM_W-1:0]   sum_all;
  logic               db_pass;
  logic [DMW-1:0]     dmag [3];
  logic [2:0]         dneg;
  logic [MW-1:0]      mprod [RAMP_LEN][3];
  logic [DMW-1:0]     q0 [RAMP_LEN][3];

  function automatic logic [PIX_W-1:0] absd(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    absd = (a > b) ? (a - b) : (b - a);
  endfunction

  // Ramp value w + floor(s*D/RAMP_LEN), clamped to a pixel
  function automatic logic [PIX_W-1:0] ramp_px(input logic [PIX_W-1:0] w,
                                               input logic [MW-1:0]    m,
                                               input logic [DMW-1:0]   q,
                                               input logic             neg);
    logic               exact;
    logic signed [9:0]  fq;
    logic signed [9:0]  v;
    exact = ((MW'(q) * MW'(RAMP_LEN)) == m);
    if (neg) begin
      fq = -$signed(10'(q)) - $signed(10'(!exact));
    end else begin
      fq = $signed(10'(q));
    end
    v = $signed({2'b00, w}) + fq;
    if (v < 0) begin
      ramp_px = '0;
    end else if (v > 10'sd255) begin
      ramp_px = 8'd255;
    end else begin
      ramp_px = v[PIX_W-1:0];
    end
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      air[0]               <= AIR_RST;
      air[1]               <= AIR_RST;
      air[2]               <= AIR_RST;
      trans_floor          <= FLOOR_RST;
      post_enable          <= 1'b0;
      post_trans_threshold <= THR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_AIR0:      air[0] <= cfg_wr_data[PIX_W-1:0];
        CFG_AIR1:      air[1] <= cfg_wr_data[PIX_W-1:0];
        CFG_AIR2:      air[2] <= cfg_wr_data[PIX_W-1:0];
        CFG_FLOOR:     trans_floor <= cfg_wr_data;
        CFG_POST_EN:   post_enable <= cfg_wr_data[0];
        CFG_THRESHOLD: post_trans_threshold <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Saturate transmission, raise it to the floor and keep the divisor nonzero
  always_comb begin
    t_sat = (DW'(transmission) > ONE) ? ONE : DW'(transmission);
    dvs   = (t_sat > DW'(trans_floor)) ? t_sat : DW'(trans_floor);
    if (dvs == '0) begin
      dvs = DW'(1);
    end
  end

  assign pix_in[0] = pixel_c0;
  assign pix_in[1] = pixel_c1;
  assign pix_in[2] = pixel_c2;

  // Hold the low transmission mark of the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mark_q <= (t_sat < DW'(post_trans_threshold));
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    dph_div #(
      .TFB (TFB),
      .DW  (DW)
    ) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (cmd.load),
      .pix   (pix_in[c]),
      .air   (air[c]),
      .dvs   (dvs),
      .done  (div_done[c]),
      .res   (div_res[c])
    );
  end

  // Gamma lookup, one channel a cycle
  always_comb begin
    if (cmd.rd_ch[1]) begin
      raddr = div_res[1];
    end else if (cmd.rd_ch[2]) begin
      raddr = div_res[2];
    end else begin
      raddr = div_res[0];
    end
  end

  dph_ram #(
    .WIDTH (PIX_W),
    .DEPTH (GAMMA_DEPTH)
  ) u_gamma (
    .clk   (clk),
    .we    (cmd.gam_wr),
    .waddr (table_index),
    .wdata (table_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.cap_ch[c]) begin
        px[c] <= rdata;
      end
    end
  end

  // Banding test on the window taps
  always_comb begin
    sum_all = '0;
    for (int c = 0; c < 3; c++) begin
      dsg[c]   = {1'b0, win[PA][PIX_W*c +: PIX_W]} - {1'b0, win[PB][PIX_W*c +: PIX_W]};
      st_ok[c] = absd(win[PA][PIX_W*c +: PIX_W], win[PB][PIX_W*c +: PIX_W])
                 < PIX_W'(STEP_LIMIT);
      sum_all  = sum_all
               + SUM_W'(absd(win[PB][PIX_W*c +: PIX_W], win[PF][PIX_W*c +: PIX_W]))
               + SUM_W'(absd(win[PA][PIX_W*c +: PIX_W], win[PN][PIX_W*c +: PIX_W]));
    end
  end

  // Step magnitude, ramp products, reciprocal quotients
  always_ff @(posedge clk) begin
    if (cmd.db1) begin
      db_pass <= marks[PA] && (&st_ok) && (sum_all < SUM_W'(SUM_LIMIT));
      for (int c = 0; c < 3; c++) begin
        dmag[c] <= DMW'(absd(win[PA][PIX_W*c +: PIX_W], win[PB][PIX_W*c +: PIX_W]));
        dneg[c] <= dsg[c][8];
      end
    end
    if (cmd.db2) begin
      for (int s = 1; s <= RAMP_LEN; s++) begin
        for (int c = 0; c < 3; c++) begin
          mprod[s-1][c] <= MW'(s * int'(dmag[c]));
        end
      end
    end
    if (cmd.db3) begin
      for (int s = 0; s < RAMP_LEN; s++) begin
        for (int c = 0; c < 3; c++) begin
          q0[s][c] <= DMW'((MPW'(mprod[s][c]) * RECIP) >> RK);
        end
      end
    end
  end

  // Shift the window, or write the ramp over it
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < WIN - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WIN-1] <= {px[2], px[1], px[0]};
    end else if (cmd.db4 && db_pass) begin
      for (int s = 1; s <= RAMP_LEN; s++) begin
        for (int c = 0; c < 3; c++) begin
          win[s][PIX_W*c +: PIX_W] <= ramp_px(win[s][PIX_W*c +: PIX_W],
                                              mprod[s-1][c], q0[s-1][c], dneg[c]);
        end
      end
    end
  end

  // Marks and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      marks   <= '0;
      pending <= '0;
      col     <= '0;
    end else if (cmd.shift) begin
      marks <= {mark_q, marks[WIN-1:1]};
      if (pending < PW'(WIN)) begin
        pending <= pending + 1'b1;
      end
      if (col < COUNT_MAX) begin
        col <= col + 1'b1;
      end
    end else if (cmd.pend_dec) begin
      pending <= pending - 1'b1;
      if (pending == PW'(1)) begin
        col <= '0;
      end
    end
  end

  assign flush_idx = IW'(PW'(WIN) - pending);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tlast <= cmd.last;
      case (cmd.src)
        SRC_HEAD:  m_tdata <= win[0];
        SRC_FLUSH: m_tdata <= win[flush_idx];
        default:   m_tdata <= {px[2], px[1], px[0]};
      endcase
    end
  end

  // Status
  assign sts.div_done  = &div_done;
  assign sts.post_en   = post_enable;
  assign sts.pend_zero = (pending == '0);
  assign sts.pend_one  = (pending == PW'(1));
  assign sts.pend_full = (pending >= PW'(WIN));
  assign sts.col_test  = (int'(col) >= WIN - 1);
  assign sts.out_free  = !m_tvalid || m_tready;

  `ASSERT_ALWAYS(a_pend_bound, clk, rst, pending <= PW'(WIN), "pending count beyond window")
  `ASSERT_ALWAYS(a_col_row, clk, rst, (pending == '0) |-> (col == '0), "column left after flush")
  `ASSERT_NEVER(a_emit_full, clk, rst, cmd.emit && m_tvalid && !m_tready, "result overwritten")

endmodule

`default_nettype wire

[sv/dph_ctrl.sv]
// ----------------------------------------------------------------------------
// dph_ctrl
// Controller: sequences division, gamma lookup, window update, debanding
// and result emission for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dph_ctrl import dph_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire logic req,
  input  wire logic eor,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'h0001,
    ST_DIV   = 15'h0002,
    ST_RD0   = 15'h0004,
    ST_RD1   = 15'h0008,
    ST_RD2   = 15'h0010,
    ST_RD3   = 15'h0020,
    ST_PX    = 15'h0040,
    ST_FLUSH = 15'h0080,
    ST_SHIFT = 15'h0100,
    ST_DB1   = 15'h0200,
    ST_DB2   = 15'h0400,
    ST_DB3   = 15'h0800,
    ST_DB4   = 15'h1000,
    ST_CHK   = 15'h2000,
    ST_HEAD  = 15'h4000
  } state_t;

  state_t state;
  state_t state_next;
  logic   row_end;

  // State register and row end flag of the request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      row_end <= eor;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (req == REQ_TABLE) begin
            cmd.gam_wr = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_RD0;
        end
      end
      ST_RD0: begin
        cmd.rd_ch  = 3'b001;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_ch  = 3'b010;
        cmd.cap_ch = 3'b001;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_ch  = 3'b100;
        cmd.cap_ch = 3'b010;
        state_next = ST_RD3;
      end
      ST_RD3: begin
        cmd.cap_ch = 3'b100;
        if (sts.post_en) begin
          state_next = ST_SHIFT;
        end else if (sts.pend_zero) begin
          state_next = ST_PX;
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_PX: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_PX;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_FLUSH;
          cmd.pend_dec = 1'b1;
          cmd.last     = sts.pend_one && sts.post_en;
          if (sts.pend_one) begin
            state_next = sts.post_en ? ST_IDLE : ST_PX;
          end
        end
      end
      ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = sts.col_test ? ST_DB1 : ST_CHK;
      end
      ST_DB1: begin
        cmd.db1    = 1'b1;
        state_next = ST_DB2;
      end
      ST_DB2: begin
        cmd.db2    = 1'b1;
        state_next = ST_DB3;
      end
      ST_DB3: begin
        cmd.db3    = 1'b1;
        state_next = ST_DB4;
      end
      ST_DB4: begin
        cmd.db4    = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (sts.pend_full) begin
          state_next = ST_HEAD;
        end else if (row_end) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_HEAD: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_HEAD;
          cmd.pend_dec = 1'b1;
          cmd.last     = !row_end;
          state_next   = row_end ? ST_FLUSH : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_emit_free, clk, rst, cmd.emit |-> sts.out_free, "emit into a full output")
  `ASSERT_ALWAYS(a_table_idle, clk, rst, (s_tvalid && s_tready && req == REQ_TABLE) |=> (state == ST_IDLE), "table write left idle")
  `ASSERT_NEVER(a_rd_busy, clk, rst, (cmd.rd_ch != 3'b000) && !sts.div_done, "lookup before division ends")

endmodule

`default_nettype wire

[sv/dehaze_pixel_restore_deband.sv]
// ----------------------------------------------------------------------------
// dehaze_pixel_restore_deband
// Haze model inversion per pixel with gamma mapping and row debanding.
// ----------------------------------------------------------------------------
// One request is handled at a time. In direct mode a pixel's result is
// loaded after the bit-serial channel dividers (one quotient bit a cycle)
// and the three lookups on the single gamma table port. In debanding mode
// the window shift and the fill check come before the delayed result is
// loaded, and the debanding steps DB1 to DB4 are added once the column
// count reaches the window length. A row end or mode change flush emits
// each further result held in the window. A gamma table write gives no
// result. The output register holds a result while the next request is
// accepted. Gamma entries read before they are written return undefined data.
// ----------------------------------------------------------------------------
`default_nettype none

module dehaze_pixel_restore_deband import dph_pkg::*; #(
  parameter int LOOKBACK        = 20,
  parameter int RAMP_LEN        = 10,
  parameter int TRANS_FRAC_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // pixel_c0[7:0], pixel_c1[15:8], pixel_c2[23:16], transmission[36:24],
  // table_index[44:37], table_value[52:45], zero [55:53]
  input  wire logic [55:0]           s_tdata,
  input  wire logic [0:0]            s_tuser,  // req_type[0]
  input  wire logic                  s_tlast,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // out_c0[7:0], out_c1[15:8], out_c2[23:16]
  output logic [23:0]                m_tdata,
  output logic                       m_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  dph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req      (s_tuser[0]),
    .eor      (s_tlast),
    .sts      (sts),
    .cmd      (cmd)
  );

  dph_dp #(
    .LOOKBACK (LOOKBACK),
    .RAMP_LEN (RAMP_LEN),
    .TFB      (TRANS_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_c0     (s_tdata[7:0]),
    .pixel_c1     (s_tdata[15:8]),
    .pixel_c2     (s_tdata[23:16]),
    .transmission (s_tdata[36:24]),
    .table_index  (s_tdata[44:37]),
    .table_value  (s_tdata[52:45]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule

`default_nettype wire
